// ===== rtl/pose_transform_point_top_assert.svh =====
// ----------------------------------------------------------------------------
// pose_transform_point_top assertion macros
// Clocked assertion helpers used by the pose transform queue (ptp_queue).
// ----------------------------------------------------------------------------
`ifndef POSE_TRANSFORM_POINT_TOP_ASSERT_SVH
`define POSE_TRANSFORM_POINT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
    `ASSERT_CLK(label, !(expr))
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// ===== rtl/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Types, constants and fixed-point helpers of the pose transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

    localparam int COORD_W = 24;
    localparam int QUAT_W  = 16;
    localparam int QFRAC   = 14;
    localparam int WIDE_W  = 48;
    localparam int PROD_W  = QUAT_W + COORD_W;
    localparam int WT_W    = QUAT_W + COORD_W - QFRAC + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_AW + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [WT_W-1:0]    t_wt;

    localparam t_wide WIDE_MAX = t_wide'(2**(COORD_W-1) - 1);
    localparam t_wide WIDE_MIN = -WIDE_MAX - t_wide'(1);
    localparam t_wide RND_HALF = t_wide'(2**(QFRAC-1));
    localparam t_quat QUAT_ONE = t_quat'(2**QFRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W,
        REG_QUAT_X,
        REG_QUAT_Y,
        REG_QUAT_Z,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_APPLY_ORDER
    } t_reg_idx;

    typedef enum logic {
        ORDER_ROT_FIRST,
        ORDER_TRANS_FIRST
    } t_order;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_point;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
    } t_result;

    typedef struct packed {
        t_quat  quat_w;
        t_quat  quat_x;
        t_quat  quat_y;
        t_quat  quat_z;
        t_coord offset_x;
        t_coord offset_y;
        t_coord offset_z;
        t_order apply_order;
    } t_pose;

    typedef struct packed {
        logic not_empty;
        logic almost_full;
    } t_q_stat;

    function automatic t_coord sat_coord(input t_wide x);
        t_coord y;
        if (x > WIDE_MAX) begin
            y = t_coord'(WIDE_MAX);
        end else if (x < WIDE_MIN) begin
            y = t_coord'(WIDE_MIN);
        end else begin
            y = t_coord'(x);
        end
        return y;
    endfunction

    // round half up, then drop the quaternion fraction
    function automatic t_wide rnd_q(input t_wide x);
        t_wide y;
        y = x + RND_HALF;
        return y >>> QFRAC;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ptp_front.sv =====
// ----------------------------------------------------------------------------
// ptp_front
// Takes points in, applies the translation ahead of rotation when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  ptp_pkg::t_point  i_point,
    input  ptp_pkg::t_pose   i_pose,
    input  ptp_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output ptp_pkg::t_point  o_data
);
    import ptp_pkg::*;

    logic   r_valid;
    t_point r_vec;
    t_point n_vec;
    logic   w_accept;

    assign w_accept = i_start && !i_q_stat.almost_full;

    always_comb begin
        if (i_pose.apply_order == ORDER_TRANS_FIRST) begin
            n_vec.point_x = sat_coord(t_wide'(i_point.point_x) + t_wide'(i_pose.offset_x));
            n_vec.point_y = sat_coord(t_wide'(i_point.point_y) + t_wide'(i_pose.offset_y));
            n_vec.point_z = sat_coord(t_wide'(i_point.point_z) + t_wide'(i_pose.offset_z));
        end else begin
            n_vec = i_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
        if (w_accept) begin
            r_vec <= n_vec;
        end
    end

    assign o_push = r_valid;
    assign o_data = r_vec;

endmodule

`default_nettype wire

// ===== rtl/ptp_queue.sv =====
// ----------------------------------------------------------------------------
// ptp_queue
// Short FIFO between the front and the rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pose_transform_point_top_assert.svh"

module ptp_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ptp_pkg::t_point  i_data,
    input  wire              i_pop,
    output ptp_pkg::t_point  o_data,
    output ptp_pkg::t_q_stat o_stat
);
    import ptp_pkg::*;

    t_point                r_mem [Q_DEPTH];
    logic [Q_AW-1:0]       r_wr;
    logic [Q_AW-1:0]       r_rd;
    logic [Q_CNT_W-1:0]    r_count;
    logic [Q_CNT_W-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data             = r_mem[r_rd];
    assign o_stat.not_empty   = (r_count != '0);
    assign o_stat.almost_full = (r_count >= Q_CNT_W'(Q_DEPTH - 1));

    `ASSERT_NEVER(a_no_overflow, (r_count == Q_CNT_W'(Q_DEPTH)) && i_push && !i_pop)
    `ASSERT_NEVER(a_no_underflow, (r_count == '0) && i_pop)
    `ASSERT_CLK(a_count_track, $past(i_rst_n) |-> (r_count == $past(r_count) + Q_CNT_W'($past(i_push)) - Q_CNT_W'($past(i_pop))))

endmodule

`default_nettype wire

// ===== rtl/ptp_back.sv =====
// ----------------------------------------------------------------------------
// ptp_back
// Rotation pipeline: cross products, second cross product, sum, then translation when rotation is applied first.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ptp_pkg::t_q_stat i_q_stat,
    input  ptp_pkg::t_point  i_data,
    input  ptp_pkg::t_pose   i_pose,
    output logic             o_pop,
    output logic             o_strobe,
    output ptp_pkg::t_result o_result
);
    import ptp_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;

    t_quat  w_q   [3];
    t_coord w_off [3];

    t_coord r_v0 [3];
    t_coord r_v1 [3];
    t_coord r_v2 [3];
    t_coord r_v3 [3];
    t_coord r_v4 [3];
    t_prod  r_pa [3];
    t_prod  r_pb [3];
    t_coord r_t  [3];
    t_prod  r_ca [3];
    t_prod  r_cb [3];
    t_prod  r_wp [3];
    t_coord r_c  [3];
    t_wt    r_wt [3];
    t_coord r_s  [3];
    t_coord r_out[3];

    t_prod  n_pa [3];
    t_prod  n_pb [3];
    t_coord n_t  [3];
    t_prod  n_ca [3];
    t_prod  n_cb [3];
    t_prod  n_wp [3];
    t_coord n_c  [3];
    t_wt    n_wt [3];
    t_coord n_s  [3];
    t_coord n_out[3];

    assign w_q[0]   = i_pose.quat_x;
    assign w_q[1]   = i_pose.quat_y;
    assign w_q[2]   = i_pose.quat_z;
    assign w_off[0] = i_pose.offset_x;
    assign w_off[1] = i_pose.offset_y;
    assign w_off[2] = i_pose.offset_z;

    assign o_pop = i_q_stat.not_empty;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = w_q[(i + 1) % 3] * r_v0[(i + 2) % 3];
            n_pb[i] = w_q[(i + 2) % 3] * r_v0[(i + 1) % 3];
            n_t[i]  = sat_coord(rnd_q((t_wide'(r_pa[i]) - t_wide'(r_pb[i])) <<< 1));
            n_ca[i] = w_q[(i + 1) % 3] * r_t[(i + 2) % 3];
            n_cb[i] = w_q[(i + 2) % 3] * r_t[(i + 1) % 3];
            n_wp[i] = i_pose.quat_w * r_t[i];
            n_c[i]  = sat_coord(rnd_q(t_wide'(r_ca[i]) - t_wide'(r_cb[i])));
            n_wt[i] = t_wt'(rnd_q(t_wide'(r_wp[i])));
            n_s[i]  = sat_coord(t_wide'(r_v4[i]) + t_wide'(r_wt[i]) + t_wide'(r_c[i]));
            if (i_pose.apply_order == ORDER_ROT_FIRST) begin
                n_out[i] = sat_coord(t_wide'(r_s[i]) + t_wide'(w_off[i]));
            end else begin
                n_out[i] = r_s[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
        if (o_pop) begin
            r_v0[0] <= i_data.point_x;
            r_v0[1] <= i_data.point_y;
            r_v0[2] <= i_data.point_z;
        end
        for (int i = 0; i < 3; i++) begin
            r_pa[i]  <= n_pa[i];
            r_pb[i]  <= n_pb[i];
            r_v1[i]  <= r_v0[i];
            r_t[i]   <= n_t[i];
            r_v2[i]  <= r_v1[i];
            r_ca[i]  <= n_ca[i];
            r_cb[i]  <= n_cb[i];
            r_wp[i]  <= n_wp[i];
            r_v3[i]  <= r_v2[i];
            r_c[i]   <= n_c[i];
            r_wt[i]  <= n_wt[i];
            r_v4[i]  <= r_v3[i];
            r_s[i]   <= n_s[i];
            r_out[i] <= n_out[i];
        end
    end

    assign o_strobe       = r_vld[NSTG-1];
    assign o_result.out_x = r_out[0];
    assign o_result.out_y = r_out[1];
    assign o_result.out_z = r_out[2];

endmodule

`default_nettype wire

// ===== rtl/pose_transform_point_top.sv =====
// ----------------------------------------------------------------------------
// pose_transform_point_top
// Rigid pose transform (unit quaternion rotation plus translation) of 3-D
// points. One point per clock while o_busy is low; each result appears on
// o_result for one cycle with o_strobe high. Each point passes through the
// input register, a short FIFO and the seven-stage rotation pipeline with
// its two rounds of multipliers. The receiver cannot stall, so o_busy only
// rises if the FIFO backs up, which does not happen in steady streaming.
// Pose registers are written through the config channel, which is always
// ready; write them only while no point is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_transform_point_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    output logic                               o_busy,
    input  ptp_pkg::t_point                    i_point,
    output logic                               o_strobe,
    output ptp_pkg::t_result                   o_result,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [ptp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [ptp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ptp_pkg::*;

    t_pose   r_pose;
    t_q_stat w_q_stat;
    logic    w_push;
    t_point  w_push_data;
    logic    w_pop;
    t_point  w_pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose.quat_w      <= QUAT_ONE;
            r_pose.quat_x      <= '0;
            r_pose.quat_y      <= '0;
            r_pose.quat_z      <= '0;
            r_pose.offset_x    <= '0;
            r_pose.offset_y    <= '0;
            r_pose.offset_z    <= '0;
            r_pose.apply_order <= ORDER_ROT_FIRST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_QUAT_W:      r_pose.quat_w   <= t_quat'(i_cfg_data[QUAT_W-1:0]);
                REG_QUAT_X:      r_pose.quat_x   <= t_quat'(i_cfg_data[QUAT_W-1:0]);
                REG_QUAT_Y:      r_pose.quat_y   <= t_quat'(i_cfg_data[QUAT_W-1:0]);
                REG_QUAT_Z:      r_pose.quat_z   <= t_quat'(i_cfg_data[QUAT_W-1:0]);
                REG_OFFSET_X:    r_pose.offset_x <= t_coord'(i_cfg_data);
                REG_OFFSET_Y:    r_pose.offset_y <= t_coord'(i_cfg_data);
                REG_OFFSET_Z:    r_pose.offset_z <= t_coord'(i_cfg_data);
                REG_APPLY_ORDER: r_pose.apply_order <= t_order'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    assign o_busy = w_q_stat.almost_full;

    ptp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_point  (i_point),
        .i_pose   (r_pose),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_data   (w_push_data)
    );

    ptp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_q_stat)
    );

    ptp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_data   (w_pop_data),
        .i_pose   (r_pose),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
